FILE: hw/rtl/kmsd_pkg.sv
// Shared types, key tables and character mapping for the key matrix scan decoder.
package kmsd_pkg;

    localparam int ROWS = 8;
    localparam int COLS = 8;

    localparam logic [5:0] CODE_SHIFT = 6'd44;
    localparam logic [5:0] CODE_LOCK  = 6'd45;
    localparam logic [5:0] CODE_CTRL  = 6'd46;
    localparam logic [5:0] CODE_FUNC  = 6'd48;

    localparam logic [7:0] CHAR_UP    = 8'd128;
    localparam logic [7:0] CHAR_LEFT  = 8'd129;
    localparam logic [7:0] CHAR_RIGHT = 8'd130;
    localparam logic [7:0] CHAR_DOWN  = 8'd131;

    typedef struct packed {
        logic       found;
        logic [5:0] code;
        logic [2:0] col;
        logic       shift;
        logic       lock;
        logic       ctrl;
        logic       func;
    } t_lane_res;

    typedef struct packed {
        logic       found;
        logic [5:0] code;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] character;
        logic       shift;
        logic       ctrl;
        logic       func;
        logic       lock;
    } t_result;

    localparam logic [5:0] KEY_TABLE [64] = '{
        6'd11, 6'd43, 6'd42, 6'd41, 6'd40, 6'd22, 6'd0,  6'd0,
        6'd47, 6'd31, 6'd30, 6'd29, 6'd28, 6'd32, 6'd0,  6'd0,
        6'd33, 6'd20, 6'd19, 6'd18, 6'd17, 6'd21, 6'd0,  6'd0,
        6'd0,  6'd9,  6'd8,  6'd7,  6'd6,  6'd10, 6'd0,  6'd0,
        6'd48, 6'd2,  6'd3,  6'd4,  6'd5,  6'd1,  6'd45, 6'd0,
        6'd44, 6'd24, 6'd25, 6'd26, 6'd27, 6'd23, 6'd0,  6'd0,
        6'd46, 6'd13, 6'd14, 6'd15, 6'd16, 6'd12, 6'd0,  6'd0,
        6'd0,  6'd36, 6'd37, 6'd38, 6'd39, 6'd35, 6'd0,  6'd0
    };

    localparam logic [7:0] PLAIN_CHAR [48] = '{
        8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "=",
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "/", "a",
        "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h0A, 8'h00, "z",
        "x", "c", "v", "b", "n", "m", ",", ".", 8'h00, 8'h00, 8'h00, " "
    };

    localparam logic [7:0] SHIFT_CHAR [48] = '{
        8'h00, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "+",
        "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "-", "A",
        "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h0A, 8'h00, "Z",
        "X", "C", "V", "B", "N", "M", "<", ">", 8'h00, 8'h00, 8'h00, " "
    };

    function automatic logic [8:0] ctrl_char(input logic [5:0] kc);
        logic [8:0] v;
        v = '0;
        case (kc)
            6'd12:   v = {1'b1, 8'd17};
            6'd24:   v = {1'b1, 8'd19};
            6'd28:   v = {1'b1, 8'd8};
            6'd35:   v = {1'b1, 8'd26};
            6'd37:   v = {1'b1, 8'd3};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] func_char(input logic [5:0] kc);
        logic [8:0] v;
        v = '0;
        case (kc)
            6'd13:   v = {1'b1, 8'h7E};
            6'd14:   v = {1'b1, CHAR_UP};
            6'd15:   v = {1'b1, 8'h5B};
            6'd16:   v = {1'b1, 8'h5D};
            6'd18:   v = {1'b1, 8'h5F};
            6'd19:   v = {1'b1, 8'h3F};
            6'd20:   v = {1'b1, 8'h27};
            6'd21:   v = {1'b1, 8'h22};
            6'd23:   v = {1'b1, 8'h7C};
            6'd24:   v = {1'b1, CHAR_LEFT};
            6'd25:   v = {1'b1, CHAR_RIGHT};
            6'd26:   v = {1'b1, 8'h7B};
            6'd27:   v = {1'b1, 8'h7D};
            6'd35:   v = {1'b1, 8'h5C};
            6'd36:   v = {1'b1, CHAR_DOWN};
            6'd37:   v = {1'b1, 8'h60};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] map_char(input logic [5:0] kc, input logic sh,
                                            input logic ct, input logic fn);
        logic [8:0] cv;
        logic [8:0] fv;
        logic [7:0] v;
        cv = ctrl_char(kc);
        fv = func_char(kc);
        if (kc >= 6'd48) begin
            v = '0;
        end else if (ct && cv[8]) begin
            v = cv[7:0];
        end else if (fn && fv[8]) begin
            v = fv[7:0];
        end else if (sh) begin
            v = SHIFT_CHAR[kc];
        end else begin
            v = PLAIN_CHAR[kc];
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/key_matrix_scan_decoder.sv
// Top level of the key matrix scan decoder: row lanes, merge stage and output register.
//
// The input channel takes one beat per snapshot: eight row bytes, bit c of a row set
// when the contact at that column is closed. The output channel gives one beat per
// snapshot: the winning key (last in row-major, low-column-first order), its row and
// column, the mapped character, and the shift, ctrl, func and lock flags seen anywhere
// in the snapshot. Fields of the key are zero when no key is closed.
// Both channels use valid and stall; a beat moves when valid is high and stall is low.
// A beat passes the lane register and then the output register: eight row lanes
// decode their rows into a registered lane result, then the merge stage picks the
// winner, maps the character and loads the output register. One snapshot is taken
// every cycle while o_stall is low. When the receiver stalls, the output holds; the
// lane register still takes a beat if it is empty, after which o_stall rises until the
// output moves on. o_stall follows i_stall in the same cycle once both stages are full.
// Reset clears both stage valid flags; no beat is in flight afterwards.
module key_matrix_scan_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_row_0_pressed,
    input  logic [7:0] i_row_1_pressed,
    input  logic [7:0] i_row_2_pressed,
    input  logic [7:0] i_row_3_pressed,
    input  logic [7:0] i_row_4_pressed,
    input  logic [7:0] i_row_5_pressed,
    input  logic [7:0] i_row_6_pressed,
    input  logic [7:0] i_row_7_pressed,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_key_found,
    output logic [5:0] o_key_code,
    output logic [2:0] o_key_row,
    output logic [2:0] o_key_column,
    output logic [7:0] o_character,
    output logic       o_shift_on,
    output logic       o_ctrl_on,
    output logic       o_func_on,
    output logic       o_lock_on
);
    import kmsd_pkg::*;

    logic [7:0] rows [ROWS];
    t_lane_res  lane_res [ROWS];
    t_lane_res  r_lane [ROWS];
    logic       r_v1;
    t_result    merged;
    t_result    r_out;
    logic       r_v2;
    logic       out_ready;
    logic       in_ready;

    assign rows[0] = i_row_0_pressed;
    assign rows[1] = i_row_1_pressed;
    assign rows[2] = i_row_2_pressed;
    assign rows[3] = i_row_3_pressed;
    assign rows[4] = i_row_4_pressed;
    assign rows[5] = i_row_5_pressed;
    assign rows[6] = i_row_6_pressed;
    assign rows[7] = i_row_7_pressed;

    for (genvar g = 0; g < ROWS; g++) begin : g_lane
        kmsd_lane u_lane (
            .i_row  (3'(g)),
            .i_bits (rows[g]),
            .o_res  (lane_res[g])
        );
    end

    kmsd_merge u_merge (
        .i_lane (r_lane),
        .o_res  (merged)
    );

    assign out_ready = !r_v2 || !i_stall;
    assign in_ready  = !r_v1 || out_ready;
    assign o_stall   = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (in_ready) begin
                r_v1 <= i_valid;
            end
            if (out_ready) begin
                r_v2 <= r_v1;
            end
        end
        if (in_ready && i_valid) begin
            r_lane <= lane_res;
        end
        if (out_ready && r_v1) begin
            r_out <= merged;
        end
    end

    assign o_valid      = r_v2;
    assign o_key_found  = r_out.found;
    assign o_key_code   = r_out.code;
    assign o_key_row    = r_out.row;
    assign o_key_column = r_out.col;
    assign o_character  = r_out.character;
    assign o_shift_on   = r_out.shift;
    assign o_ctrl_on    = r_out.ctrl;
    assign o_func_on    = r_out.func;
    assign o_lock_on    = r_out.lock;

endmodule

FILE: hw/rtl/kmsd_lane.sv
// One row lane: looks up every closed contact of a row and finds its last key and modifiers.
module kmsd_lane (
    input  logic [2:0]          i_row,
    input  logic [7:0]          i_bits,
    output kmsd_pkg::t_lane_res o_res
);
    import kmsd_pkg::*;

    logic [5:0] kc [COLS];
    t_lane_res  res;

    always_comb begin
        res = '0;
        for (int c = 0; c < COLS; c++) begin
            kc[c] = KEY_TABLE[{i_row, 3'(c)}];
            if (i_bits[c] && kc[c] != 6'd0) begin
                if (kc[c] == CODE_SHIFT) begin
                    res.shift = 1'b1;
                end else if (kc[c] == CODE_LOCK) begin
                    res.shift = 1'b1;
                    res.lock  = 1'b1;
                end else if (kc[c] == CODE_CTRL) begin
                    res.ctrl = 1'b1;
                end else if (kc[c] == CODE_FUNC) begin
                    res.func = 1'b1;
                end else begin
                    res.found = 1'b1;
                    res.code  = kc[c];
                    res.col   = 3'(c);
                end
            end
        end
    end

    assign o_res = res;

endmodule

FILE: hw/rtl/kmsd_merge.sv
// Merging stage: picks the key of the highest row, combines modifiers and maps the character.
module kmsd_merge (
    input  kmsd_pkg::t_lane_res i_lane [kmsd_pkg::ROWS],
    output kmsd_pkg::t_result   o_res
);
    import kmsd_pkg::*;

    t_result res;

    always_comb begin
        res = '0;
        for (int r = 0; r < ROWS; r++) begin
            res.shift = res.shift | i_lane[r].shift;
            res.lock  = res.lock  | i_lane[r].lock;
            res.ctrl  = res.ctrl  | i_lane[r].ctrl;
            res.func  = res.func  | i_lane[r].func;
            if (i_lane[r].found) begin
                res.found = 1'b1;
                res.code  = i_lane[r].code;
                res.row   = 3'(r);
                res.col   = i_lane[r].col;
            end
        end
        res.character = res.found ? map_char(res.code, res.shift, res.ctrl, res.func) : 8'd0;
    end

    assign o_res = res;

endmodule

FILE: test/key_matrix_scan_decoder_test.sv
// Self-checking testbench for the key matrix scan decoder: directed and random snapshots.
module key_matrix_scan_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kmsd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    localparam int POS_FUNC  = 32;
    localparam int POS_LOCK  = 38;
    localparam int POS_SHIFT = 40;
    localparam int POS_CTRL  = 48;

    localparam logic [63:0] EMPTY_POSITIONS = 64'hC1C0_C080_C1C0_C0C0;

    localparam logic [5:0] KEY_AT [64] = '{
        6'd11, 6'd43, 6'd42, 6'd41, 6'd40, 6'd22, 6'd0,  6'd0,
        6'd47, 6'd31, 6'd30, 6'd29, 6'd28, 6'd32, 6'd0,  6'd0,
        6'd33, 6'd20, 6'd19, 6'd18, 6'd17, 6'd21, 6'd0,  6'd0,
        6'd0,  6'd9,  6'd8,  6'd7,  6'd6,  6'd10, 6'd0,  6'd0,
        6'd48, 6'd2,  6'd3,  6'd4,  6'd5,  6'd1,  6'd45, 6'd0,
        6'd44, 6'd24, 6'd25, 6'd26, 6'd27, 6'd23, 6'd0,  6'd0,
        6'd46, 6'd13, 6'd14, 6'd15, 6'd16, 6'd12, 6'd0,  6'd0,
        6'd0,  6'd36, 6'd37, 6'd38, 6'd39, 6'd35, 6'd0,  6'd0
    };

    localparam logic [7:0] LOWER_GLYPH [48] = '{
        8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "=",
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "/", "a",
        "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h0A, 8'h00, "z",
        "x", "c", "v", "b", "n", "m", ",", ".", 8'h00, 8'h00, 8'h00, " "
    };

    localparam logic [7:0] UPPER_GLYPH [48] = '{
        8'h00, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "+",
        "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "-", "A",
        "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h0A, 8'h00, "Z",
        "X", "C", "V", "B", "N", "M", "<", ">", 8'h00, 8'h00, 8'h00, " "
    };

    typedef struct packed {
        logic       found;
        logic [5:0] code;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] glyph;
        logic       shift;
        logic       ctrl;
        logic       func;
        logic       lock;
    } t_decoded;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] rows_drive;
    logic        o_valid;
    logic        i_stall;
    logic        o_key_found;
    logic [5:0]  o_key_code;
    logic [2:0]  o_key_row;
    logic [2:0]  o_key_column;
    logic [7:0]  o_character;
    logic        o_shift_on;
    logic        o_ctrl_on;
    logic        o_func_on;
    logic        o_lock_on;

    t_decoded pending_decodes [$];
    int       errors;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       quiet_cycles;

    key_matrix_scan_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_row_0_pressed(rows_drive[7:0]),
        .i_row_1_pressed(rows_drive[15:8]),
        .i_row_2_pressed(rows_drive[23:16]),
        .i_row_3_pressed(rows_drive[31:24]),
        .i_row_4_pressed(rows_drive[39:32]),
        .i_row_5_pressed(rows_drive[47:40]),
        .i_row_6_pressed(rows_drive[55:48]),
        .i_row_7_pressed(rows_drive[63:56]),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_key_found    (o_key_found),
        .o_key_code     (o_key_code),
        .o_key_row      (o_key_row),
        .o_key_column   (o_key_column),
        .o_character    (o_character),
        .o_shift_on     (o_shift_on),
        .o_ctrl_on      (o_ctrl_on),
        .o_func_on      (o_func_on),
        .o_lock_on      (o_lock_on)
    );

    function automatic int ctrl_glyph(input logic [5:0] code);
        case (code)
            6'd12:   return 17;
            6'd24:   return 19;
            6'd28:   return 8;
            6'd35:   return 26;
            6'd37:   return 3;
            default: return -1;
        endcase
    endfunction

    function automatic int func_glyph(input logic [5:0] code);
        case (code)
            6'd13:   return 8'h7E;
            6'd14:   return CHAR_UP;
            6'd15:   return 8'h5B;
            6'd16:   return 8'h5D;
            6'd18:   return 8'h5F;
            6'd19:   return 8'h3F;
            6'd20:   return 8'h27;
            6'd21:   return 8'h22;
            6'd23:   return 8'h7C;
            6'd24:   return CHAR_LEFT;
            6'd25:   return CHAR_RIGHT;
            6'd26:   return 8'h7B;
            6'd27:   return 8'h7D;
            6'd35:   return 8'h5C;
            6'd36:   return CHAR_DOWN;
            6'd37:   return 8'h60;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] glyph_for(input logic [5:0] code, input logic shift,
                                             input logic ctrl, input logic func);
        int v;
        v = -1;
        if (code >= 6'd48) begin
            return 8'h00;
        end
        if (ctrl) begin
            v = ctrl_glyph(code);
        end
        if (v < 0 && func) begin
            v = func_glyph(code);
        end
        if (v >= 0) begin
            return v[7:0];
        end
        return shift ? UPPER_GLYPH[code] : LOWER_GLYPH[code];
    endfunction

    function automatic t_decoded predict_decode(input logic [63:0] snap);
        t_decoded d;
        logic [5:0] kc;
        d = '0;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                if (snap[8 * r + c]) begin
                    kc = KEY_AT[8 * r + c];
                    if (kc == 6'd0) begin
                    end else if (kc == CODE_SHIFT) begin
                        d.shift = 1'b1;
                    end else if (kc == CODE_LOCK) begin
                        d.shift = 1'b1;
                        d.lock = 1'b1;
                    end else if (kc == CODE_CTRL) begin
                        d.ctrl = 1'b1;
                    end else if (kc == CODE_FUNC) begin
                        d.func = 1'b1;
                    end else begin
                        d.found = 1'b1;
                        d.code = kc;
                        d.row = r[2:0];
                        d.col = c[2:0];
                    end
                end
            end
        end
        if (d.found) begin
            d.glyph = glyph_for(d.code, d.shift, d.ctrl, d.func);
        end
        return d;
    endfunction

    function automatic logic [63:0] contact(input int r, input int c);
        return 64'd1 << (8 * r + c);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected,
                     actual);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_decoded want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_decodes.size() == 0) begin
                $display("%0t: result beat with no snapshot outstanding", $time);
                errors++;
            end else begin
                want = pending_decodes.pop_front();
                compare_field("key_found", want.found, o_key_found);
                compare_field("key_code", want.code, o_key_code);
                compare_field("key_row", want.row, o_key_row);
                compare_field("key_column", want.col, o_key_column);
                compare_field("character", want.glyph, o_character);
                compare_field("shift_on", want.shift, o_shift_on);
                compare_field("ctrl_on", want.ctrl, o_ctrl_on);
                compare_field("func_on", want.func, o_func_on);
                compare_field("lock_on", want.lock, o_lock_on);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_snapshot(input logic [63:0] snap);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        rows_drive <= snap;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_decodes.push_back(predict_decode(snap));
        @(negedge i_clk);
    endtask

    task automatic test_blank_and_full();
        send_snapshot(64'd0);
        send_snapshot({64{1'b1}});
    endtask

    task automatic test_modifiers_alone();
        send_snapshot(64'd1 << POS_SHIFT);
        send_snapshot(64'd1 << POS_LOCK);
        send_snapshot(64'd1 << POS_CTRL);
        send_snapshot(64'd1 << POS_FUNC);
        send_snapshot((64'd1 << POS_SHIFT) | (64'd1 << POS_LOCK) | (64'd1 << POS_CTRL) |
                      (64'd1 << POS_FUNC));
    endtask

    task automatic test_ignored_positions();
        send_snapshot(EMPTY_POSITIONS);
        send_snapshot(EMPTY_POSITIONS | (64'd1 << POS_SHIFT));
    endtask

    task automatic test_key_priority();
        send_snapshot(contact(0, 0) | contact(0, 5));
        send_snapshot(contact(0, 5) | contact(1, 0));
        send_snapshot(contact(7, 1) | contact(3, 5));
        send_snapshot(contact(7, 1) | contact(7, 5));
        send_snapshot(contact(4, 5) | (64'd1 << POS_FUNC) | (64'd1 << POS_LOCK));
    endtask

    task automatic test_character_modes();
        send_snapshot(contact(6, 5));
        send_snapshot(contact(6, 5) | (64'd1 << POS_CTRL));
        send_snapshot(contact(6, 5) | (64'd1 << POS_SHIFT));
        send_snapshot(contact(6, 5) | (64'd1 << POS_SHIFT) | (64'd1 << POS_CTRL));
        send_snapshot(contact(4, 5) | (64'd1 << POS_SHIFT) | (64'd1 << POS_CTRL));
        send_snapshot(contact(4, 5) | (64'd1 << POS_SHIFT) | (64'd1 << POS_FUNC));
        send_snapshot(contact(6, 2) | (64'd1 << POS_FUNC));
        send_snapshot(contact(5, 1) | (64'd1 << POS_FUNC));
        send_snapshot(contact(5, 1) | (64'd1 << POS_FUNC) | (64'd1 << POS_CTRL));
        send_snapshot(contact(5, 2) | (64'd1 << POS_FUNC));
        send_snapshot(contact(7, 1) | (64'd1 << POS_FUNC));
        send_snapshot(contact(6, 1) | (64'd1 << POS_LOCK));
        send_snapshot(contact(1, 0) | (64'd1 << POS_SHIFT));
    endtask

    // Most snapshots are sparse so that keys in every row win and modifiers mix freely.
    task automatic test_random_snapshots(input int count);
        logic [63:0] snap;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 70) begin
                snap = '0;
                repeat ($urandom_range(3)) begin
                    snap |= 64'd1 << $urandom_range(63);
                end
                if ($urandom_range(1)) snap |= 64'd1 << POS_SHIFT;
                if ($urandom_range(3) == 0) snap |= 64'd1 << POS_LOCK;
                if ($urandom_range(1)) snap |= 64'd1 << POS_CTRL;
                if ($urandom_range(1)) snap |= 64'd1 << POS_FUNC;
            end else begin
                snap = {$urandom, $urandom};
            end
            send_snapshot(snap);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        rows_drive = '0;
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 21;
        recv_idle_pct = 74;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_blank_and_full();
        test_modifiers_alone();
        test_ignored_positions();
        test_key_priority();
        test_character_modes();
        test_random_snapshots(233);

        send_idle_pct = 74;
        recv_idle_pct = 21;
        test_random_snapshots(233);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_snapshots(234);
        i_valid <= 1'b0;

        while (pending_decodes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/kmsd_pkg.sv
hw/rtl/kmsd_lane.sv
hw/rtl/kmsd_merge.sv
hw/rtl/key_matrix_scan_decoder.sv
test/key_matrix_scan_decoder_test.sv
